[hdl/grid_dijkstra_shortest_path_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the grid shortest-path engine
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef GRID_DIJKSTRA_SHORTEST_PATH_ASSERT_SVH
`define GRID_DIJKSTRA_SHORTEST_PATH_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define GDSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define GDSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gdsp_pkg.sv]
// ----------------------------------------------------------------------------
// gdsp_pkg
// Types and constants shared by the grid shortest-path engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gdsp_pkg;

  localparam int DIST_W  = 26;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam int NODE_W  = 10;
  localparam int CFG_W   = 11;
  localparam int PW      = 2 * CFG_W;
  localparam int EDGE_W  = 4;
  localparam int WIN_W   = 16;
  localparam int IN_W    = 80;
  localparam int OUT_W   = 48;

  // layout of one lane entry: {pred, dist, last column, first column, mark}
  localparam int E_MARK_LO = 0;
  localparam int E_FIRST   = 2;
  localparam int E_LAST    = 3;
  localparam int E_DIST_LO = 4;
  localparam int E_PRED_LO = E_DIST_LO + DIST_W;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNREACH = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NORUN   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MARK_UNSEEN = 2'd0,
    MARK_FRONT  = 2'd1,
    MARK_DONE   = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    CFG_ROWS   = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_SOURCE = 2'd2,
    CFG_TARGET = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_CLR,
    FSM_SCAN,
    FSM_DRAIN1,
    FSM_DRAIN2,
    FSM_PICK,
    FSM_WGT,
    FSM_NRD,
    FSM_NWR,
    FSM_RDN,
    FSM_RPT,
    FSM_EMIT
  } fsm_e;

endpackage

`default_nettype wire

[hdl/gdsp_lane.sv]
// ----------------------------------------------------------------------------
// gdsp_lane
// One bank of node entries (every LANES-th node) with a running minimum
// over the frontier nodes it sees during a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module gdsp_lane import gdsp_pkg::*; #(
  parameter int NB      = 10,
  parameter int LB      = 2,
  parameter int LANE_ID = 0,
  localparam int RB     = NB - LB,
  localparam int EW     = E_PRED_LO + NB
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_en_i,
  input  wire logic [RB-1:0] wr_row_i,
  input  wire logic [EW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [RB-1:0] rd_row_i,
  input  wire logic          scan_en_i,
  input  wire logic          scan_clr_i,
  input  wire logic [NB:0]   node_lim_i,
  output logic      [EW-1:0] rd_data_o,
  output logic               min_vld_o,
  output logic      [NB-1:0] min_idx_o,
  output logic      [EW-1:0] min_ent_o
);

  localparam int DEPTH = 1 << RB;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q;
  logic [RB-1:0] row_q;
  logic          scan_vld_q;
  logic          min_vld_q;
  logic [NB-1:0] min_idx_q;
  logic [EW-1:0] min_ent_q;
  logic [NB-1:0] idx_w;
  logic          better_w;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q  <= mem[rd_row_i];
      row_q <= rd_row_i;
    end
  end

  assign idx_w = {row_q, LB'(LANE_ID)};

  // rows are scanned in ascending order, so a strict compare keeps the lowest index
  always_comb begin
    better_w = scan_vld_q && (rd_q[E_MARK_LO +: 2] == MARK_FRONT) &&
               ({1'b0, idx_w} < node_lim_i) &&
               (!min_vld_q ||
                (rd_q[E_DIST_LO +: DIST_W] < min_ent_q[E_DIST_LO +: DIST_W]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
      min_vld_q  <= 1'b0;
    end else begin
      scan_vld_q <= rd_en_i && scan_en_i;
      if (scan_clr_i) begin
        min_vld_q <= 1'b0;
      end else if (better_w) begin
        min_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (better_w) begin
      min_idx_q <= idx_w;
      min_ent_q <= rd_q;
    end
  end

  assign rd_data_o = rd_q;
  assign min_vld_o = min_vld_q;
  assign min_idx_o = min_idx_q;
  assign min_ent_o = min_ent_q;

endmodule

`default_nettype wire

[hdl/gdsp_merge.sv]
// ----------------------------------------------------------------------------
// gdsp_merge
// Combine the lane minima into the nearest frontier node, lowest index on
// a tie, and register it.
// ----------------------------------------------------------------------------
`default_nettype none

module gdsp_merge import gdsp_pkg::*; #(
  parameter int LANES = 4,
  parameter int NB    = 10,
  localparam int EW   = E_PRED_LO + NB
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i [LANES],
  input  wire logic [NB-1:0] idx_i [LANES],
  input  wire logic [EW-1:0] ent_i [LANES],
  output logic               vld_o,
  output logic      [NB-1:0] idx_o,
  output logic      [EW-1:0] ent_o
);

  logic              best_v;
  logic [NB-1:0]     best_i;
  logic [EW-1:0]     best_e;
  logic [DIST_W-1:0] best_d;
  logic              vld_q;
  logic [NB-1:0]     idx_q;
  logic [EW-1:0]     ent_q;

  always_comb begin
    best_v = 1'b0;
    best_i = '0;
    best_e = '0;
    best_d = '0;
    for (int l = 0; l < LANES; l++) begin
      if (vld_i[l] && (!best_v || (ent_i[l][E_DIST_LO +: DIST_W] < best_d) ||
          ((ent_i[l][E_DIST_LO +: DIST_W] == best_d) && (idx_i[l] < best_i)))) begin
        best_v = 1'b1;
        best_i = idx_i[l];
        best_e = ent_i[l];
        best_d = ent_i[l][E_DIST_LO +: DIST_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= best_v;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= best_i;
    ent_q <= best_e;
  end

  assign vld_o = vld_q;
  assign idx_o = idx_q;
  assign ent_o = ent_q;

endmodule

`default_nettype wire

[hdl/grid_dijkstra_shortest_path.sv]
// ----------------------------------------------------------------------------
// grid_dijkstra_shortest_path
// Single-source shortest paths over a rows-by-cols grid of four-way nodes.
// ----------------------------------------------------------------------------
// A load item is written straight into the edge store. A query that is
// answered at once (no run yet, or node outside the grid) goes from idle
// straight to emit, a query that reads the node first passes through the
// read and report states. A run first writes every node entry of the lane
// banks, then repeats per settled node: a scan of ceil(n/LANES) rows
// (n = rows*cols) across the lane banks, drain and merge, a fetch of the
// edge weights, then for each direction a read of the neighbour entry if the
// edge exists and a write-back if the neighbour is unseen or its distance
// shrinks. After the last node the target entry is read back. A query or run
// whose result finds the previous one still held in the output register
// waits until it is taken. After reset every node of the edge store is
// cleared, one node a cycle, during which no item is taken. LANES must be a
// power of two of at least two and at most MAX_NODES/2.
`default_nettype none

module grid_dijkstra_shortest_path import gdsp_pkg::*; #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 16,
  parameter int LANES       = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // node_id[9:0], edge_present[13:10], weight_up[29:14], weight_right[45:30],
  // weight_left[61:46], weight_down[77:62], zero[79:78]
  input  wire logic [IN_W-1:0]      s_axis_tdata,
  // cmd[1:0]
  input  wire logic [1:0]           s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // status[1:0], node_out[11:2], distance[37:12], predecessor[47:38]
  output logic      [OUT_W-1:0]     m_axis_tdata,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int NB = $clog2(MAX_NODES);
  localparam int LB = $clog2(LANES);
  localparam int RB = NB - LB;
  localparam int EW = E_PRED_LO + NB;
  localparam int WW = 4 * WEIGHT_BITS + EDGE_W;
  localparam int CW = NB + 1;

  // configuration
  logic [CFG_W-1:0]  rows_q, cols_q;
  logic [NODE_W-1:0] src_q, tgt_q;

  // control
  fsm_e              state_q, state_d;
  logic [CW-1:0]     cnt_q;
  logic [CFG_W-1:0]  col_q;
  logic [1:0]        dir_q;
  logic              run_done_q;
  logic              m_valid_q;
  logic [OUT_W-1:0]  m_data_q;

  // datapath
  logic [NB-1:0]       cur_q, nb_q, rpt_q;
  logic [DIST_W-1:0]   curd_q;
  logic                cur_first_q, cur_last_q;
  logic [1:0]          res_status_q;
  logic [NODE_W-1:0]   res_node_q, res_pred_q;
  logic [DIST_W-1:0]   res_dist_q;

  // edge store
  logic [WW-1:0] wmem [MAX_NODES];
  logic [WW-1:0] wm_rd_q;
  logic          wm_we, wm_re;
  logic [NB-1:0] wm_waddr, wm_raddr;
  logic [WW-1:0] wm_wdata;

  // lanes
  logic          ln_we [LANES];
  logic [RB-1:0] ln_wrow, ln_rrow;
  logic [EW-1:0] ln_wdata;
  logic          ln_re, scan_en, scan_clr;
  logic [EW-1:0] ln_rd  [LANES];
  logic          ln_mv  [LANES];
  logic [NB-1:0] ln_mi  [LANES];
  logic [EW-1:0] ln_me  [LANES];
  logic          mrg_vld;
  logic [NB-1:0] mrg_idx;
  logic [EW-1:0] mrg_ent;

  // combinational helpers
  logic              in_acc;
  cmd_e              in_cmd;
  logic [NODE_W-1:0] in_node;
  logic [PW-1:0]     node_ext, src_ext, tgt_ext, cnt_ext, cur_ext, cols_ext;
  logic [PW-1:0]     prod_w, nrows_w, nb_ext;
  logic              grid_bad, run_bad, node_ok;
  logic [WW-1:0]     load_word;
  logic              edge_ex;
  logic [NB-1:0]     nb_w;
  logic [WEIGHT_BITS-1:0] w_sel;
  logic [DIST_W:0]   nd_sum;
  logic [DIST_W-1:0] nd_w;
  logic [EW-1:0]     nb_ent, rpt_ent;
  logic              relax_upd;
  logic [PW-1:0]     pred_ext;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_cmd  = cmd_e'(s_axis_tuser);
  assign in_node = s_axis_tdata[NODE_W-1:0];

  assign node_ext = PW'(in_node);
  assign src_ext  = PW'(src_q);
  assign tgt_ext  = PW'(tgt_q);
  assign cnt_ext  = PW'(cnt_q);
  assign cur_ext  = PW'(cur_q);
  assign cols_ext = PW'(cols_q);
  assign prod_w   = PW'(rows_q) * cols_ext;
  assign nrows_w  = (prod_w + PW'(LANES - 1)) >> LB;
  assign grid_bad = (rows_q == '0) || (cols_q == '0) || (prod_w > PW'(MAX_NODES));
  assign run_bad  = grid_bad || (src_ext >= prod_w) || (tgt_ext >= prod_w);
  assign node_ok  = node_ext < PW'(MAX_NODES);

  always_comb begin
    load_word = '0;
    load_word[EDGE_W-1:0] = s_axis_tdata[NODE_W +: EDGE_W];
    for (int k = 0; k < 4; k++) begin
      load_word[EDGE_W + k*WEIGHT_BITS +: WEIGHT_BITS] =
        s_axis_tdata[NODE_W + EDGE_W + k*WIN_W +: WEIGHT_BITS];
    end
  end

  // neighbour of the settled node in the current direction
  always_comb begin
    edge_ex = 1'b0;
    nb_ext  = cur_ext;
    case (dir_e'(dir_q))
      DIR_UP: begin
        edge_ex = wm_rd_q[0] && (cur_ext >= cols_ext);
        nb_ext  = cur_ext - cols_ext;
      end
      DIR_RIGHT: begin
        edge_ex = wm_rd_q[1] && !cur_last_q;
        nb_ext  = cur_ext + PW'(1);
      end
      DIR_LEFT: begin
        edge_ex = wm_rd_q[2] && !cur_first_q;
        nb_ext  = cur_ext - PW'(1);
      end
      DIR_DOWN: begin
        edge_ex = wm_rd_q[3] && ((cur_ext + cols_ext) < prod_w);
        nb_ext  = cur_ext + cols_ext;
      end
      default: begin
        edge_ex = 1'b0;
        nb_ext  = cur_ext;
      end
    endcase
  end
  assign nb_w = nb_ext[NB-1:0];

  assign w_sel     = wm_rd_q[EDGE_W + dir_q*WEIGHT_BITS +: WEIGHT_BITS];
  assign nd_sum    = (DIST_W+1)'(curd_q) + (DIST_W+1)'(w_sel);
  assign nd_w      = nd_sum[DIST_W] ? DIST_MAX : nd_sum[DIST_W-1:0];
  assign nb_ent    = ln_rd[nb_q[LB-1:0]];
  assign rpt_ent   = ln_rd[rpt_q[LB-1:0]];
  assign relax_upd = (nb_ent[E_MARK_LO +: 2] == MARK_UNSEEN) ||
                     ((nb_ent[E_MARK_LO +: 2] == MARK_FRONT) &&
                      (nd_w < nb_ent[E_DIST_LO +: DIST_W]));
  assign pred_ext  = PW'(rpt_ent[E_PRED_LO +: NB]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_INIT: begin
        if (cnt_q == CW'(MAX_NODES - 1)) state_d = FSM_IDLE;
      end
      FSM_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_RUN:   state_d = run_bad ? FSM_EMIT : FSM_CLR;
            CMD_QUERY: state_d = (!run_done_q || grid_bad || (node_ext >= prod_w)) ?
                                 FSM_EMIT : FSM_RDN;
            default:   state_d = FSM_IDLE;
          endcase
        end
      end
      // reset every entry, so nodes outside the current grid read as unseen
      FSM_CLR: begin
        if (cnt_q == CW'(MAX_NODES - 1)) state_d = FSM_SCAN;
      end
      FSM_SCAN: begin
        if (cnt_ext == nrows_w - PW'(1)) state_d = FSM_DRAIN1;
      end
      FSM_DRAIN1: state_d = FSM_DRAIN2;
      FSM_DRAIN2: state_d = FSM_PICK;
      FSM_PICK:   state_d = mrg_vld ? FSM_WGT : FSM_RDN;
      FSM_WGT:    state_d = FSM_NRD;
      FSM_NRD: begin
        if (edge_ex) begin
          state_d = FSM_NWR;
        end else if (dir_q == DIR_DOWN) begin
          state_d = FSM_SCAN;
        end
      end
      FSM_NWR:    state_d = (dir_q == DIR_DOWN) ? FSM_SCAN : FSM_NRD;
      FSM_RDN:    state_d = FSM_RPT;
      FSM_RPT:    state_d = FSM_EMIT;
      FSM_EMIT: begin
        if (!m_valid_q || m_axis_tready) state_d = FSM_IDLE;
      end
      default:    state_d = FSM_INIT;
    endcase
  end

  // memory and lane controls
  always_comb begin
    s_axis_tready = 1'b0;
    wm_we    = 1'b0;
    wm_waddr = '0;
    wm_wdata = '0;
    wm_re    = 1'b0;
    wm_raddr = '0;
    ln_wrow  = '0;
    ln_wdata = '0;
    ln_re    = 1'b0;
    ln_rrow  = '0;
    scan_en  = 1'b0;
    scan_clr = 1'b0;
    for (int l = 0; l < LANES; l++) ln_we[l] = 1'b0;
    case (state_q)
      FSM_INIT: begin
        wm_we    = 1'b1;
        wm_waddr = cnt_q[NB-1:0];
      end
      FSM_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc && (in_cmd == CMD_LOAD) && node_ok) begin
          wm_we    = 1'b1;
          wm_waddr = node_ext[NB-1:0];
          wm_wdata = load_word;
        end
      end
      FSM_CLR: begin
        scan_clr = 1'b1;
        ln_we[cnt_q[LB-1:0]] = 1'b1;
        ln_wrow  = cnt_q[NB-1:LB];
        ln_wdata = {cnt_q[NB-1:0], {DIST_W{1'b0}}, (col_q == cols_q - CFG_W'(1)),
                    (col_q == '0),
                    (cnt_ext == src_ext) ? MARK_FRONT : MARK_UNSEEN};
      end
      FSM_SCAN: begin
        ln_re   = 1'b1;
        ln_rrow = cnt_q[RB-1:0];
        scan_en = 1'b1;
      end
      FSM_PICK: begin
        scan_clr = 1'b1;
        if (mrg_vld) begin
          ln_we[mrg_idx[LB-1:0]] = 1'b1;
          ln_wrow  = mrg_idx[NB-1:LB];
          ln_wdata = {mrg_ent[EW-1:E_FIRST], MARK_DONE};
          wm_re    = 1'b1;
          wm_raddr = mrg_idx;
        end
      end
      FSM_NRD: begin
        if (edge_ex) begin
          ln_re   = 1'b1;
          ln_rrow = nb_w[NB-1:LB];
        end
      end
      FSM_NWR: begin
        if (relax_upd) begin
          ln_we[nb_q[LB-1:0]] = 1'b1;
          ln_wrow  = nb_q[NB-1:LB];
          ln_wdata = {cur_q, nd_w, nb_ent[E_LAST], nb_ent[E_FIRST], MARK_FRONT};
        end
      end
      FSM_RDN: begin
        ln_re   = 1'b1;
        ln_rrow = rpt_q[NB-1:LB];
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      wmem[wm_waddr] <= wm_wdata;
    end
    if (wm_re) begin
      wm_rd_q <= wmem[wm_raddr];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    gdsp_lane #(
      .NB      (NB),
      .LB      (LB),
      .LANE_ID (l)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (ln_we[l]),
      .wr_row_i   (ln_wrow),
      .wr_data_i  (ln_wdata),
      .rd_en_i    (ln_re),
      .rd_row_i   (ln_rrow),
      .scan_en_i  (scan_en),
      .scan_clr_i (scan_clr),
      .node_lim_i (prod_w[NB:0]),
      .rd_data_o  (ln_rd[l]),
      .min_vld_o  (ln_mv[l]),
      .min_idx_o  (ln_mi[l]),
      .min_ent_o  (ln_me[l])
    );
  end

  gdsp_merge #(
    .LANES (LANES),
    .NB    (NB)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (ln_mv),
    .idx_i  (ln_mi),
    .ent_i  (ln_me),
    .vld_o  (mrg_vld),
    .idx_o  (mrg_idx),
    .ent_o  (mrg_ent)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FSM_INIT;
      cnt_q      <= '0;
      col_q      <= '0;
      dir_q      <= DIR_UP;
      run_done_q <= 1'b0;
      m_valid_q  <= 1'b0;
      rows_q     <= CFG_W'(1);
      cols_q     <= CFG_W'(1);
      src_q      <= '0;
      tgt_q      <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CW'(1);
      if (state_q == FSM_CLR) begin
        col_q <= (col_q == cols_q - CFG_W'(1)) ? '0 : col_q + CFG_W'(1);
      end else begin
        col_q <= '0;
      end
      if (state_q == FSM_WGT) begin
        dir_q <= DIR_UP;
      end else if ((state_q == FSM_NWR) || ((state_q == FSM_NRD) && !edge_ex)) begin
        dir_q <= dir_q + 2'd1;
      end
      if (in_acc && (in_cmd == CMD_RUN) && run_bad) begin
        run_done_q <= 1'b0;
      end else if ((state_q == FSM_PICK) && !mrg_vld) begin
        run_done_q <= 1'b1;
      end
      if ((state_q == FSM_EMIT) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_e'(cfg_index_i))
          CFG_ROWS:   rows_q <= cfg_data_i;
          CFG_COLS:   cols_q <= cfg_data_i;
          CFG_SOURCE: src_q  <= cfg_data_i[NODE_W-1:0];
          CFG_TARGET: tgt_q  <= cfg_data_i[NODE_W-1:0];
          default:    rows_q <= rows_q;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if ((state_q == FSM_IDLE) && in_acc) begin
      res_dist_q <= '0;
      res_pred_q <= '0;
      if (in_cmd == CMD_RUN) begin
        res_node_q   <= tgt_q;
        res_status_q <= ST_RANGE;
        rpt_q        <= tgt_ext[NB-1:0];
      end else begin
        res_node_q   <= in_node;
        res_status_q <= !run_done_q ? ST_NORUN : ST_RANGE;
        rpt_q        <= node_ext[NB-1:0];
      end
    end
    if (state_q == FSM_PICK) begin
      cur_q       <= mrg_idx;
      curd_q      <= mrg_ent[E_DIST_LO +: DIST_W];
      cur_first_q <= mrg_ent[E_FIRST];
      cur_last_q  <= mrg_ent[E_LAST];
    end
    if (state_q == FSM_NRD) begin
      nb_q <= nb_w;
    end
    if (state_q == FSM_RPT) begin
      if (rpt_ent[E_MARK_LO +: 2] == MARK_DONE) begin
        res_status_q <= ST_OK;
        res_dist_q   <= rpt_ent[E_DIST_LO +: DIST_W];
        res_pred_q   <= pred_ext[NODE_W-1:0];
      end else begin
        res_status_q <= ST_UNREACH;
        res_dist_q   <= '0;
        res_pred_q   <= '0;
      end
    end
    if ((state_q == FSM_EMIT) && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {res_pred_q, res_dist_q, res_node_q, res_status_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

`include "grid_dijkstra_shortest_path_assert.svh"

  `GDSP_ASSERT_NOW(a_pick_front, (state_q == FSM_PICK) && mrg_vld,
    mrg_ent[E_MARK_LO +: 2] == MARK_FRONT, "settled node was not on the frontier")
  `GDSP_ASSERT_NOW(a_nb_in_grid, state_q == FSM_NWR, PW'(nb_q) < prod_w,
    "neighbour outside the grid")
  `GDSP_ASSERT_NEXT(a_emit_valid, (state_q == FSM_EMIT) && (state_d == FSM_IDLE),
    m_axis_tvalid, "result not presented after emit")
  `GDSP_ASSERT_NOW(a_bad_zero, m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK),
    m_axis_tdata[OUT_W-1:12] == '0, "distance or predecessor set on a failed result")

endmodule

`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for the grid shortest-path engine
// Loads grids of weighted four-way nodes, runs searches and queries nodes.
// Every answer is checked field by field against a behavioural predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top import gdsp_pkg::*;;

  localparam int NODES    = 1024;
  localparam int LIMIT    = 6000000;
  localparam int N_ITEMS  = 1200;
  localparam int END_WAIT = 200;

  typedef struct {
    status_e          st;
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] path_len;
    logic [NODE_W-1:0] pred;
  } answer_t;

  class path_scoreboard;
    answer_t waiting[$];
    int      mismatches;

    function void note_answer(answer_t a);
      waiting.push_back(a);
    endfunction

    function void check_answer(logic [OUT_W-1:0] d);
      answer_t got;
      answer_t exp;
      got.st       = status_e'(d[1:0]);
      got.node     = d[11:2];
      got.path_len = d[37:12];
      got.pred     = d[47:38];
      if (waiting.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected answer: st=%0d node=%0d dist=%0d pred=%0d",
                   got.st, got.node, got.path_len, got.pred);
        return;
      end
      exp = waiting.pop_front();
      if (got.st !== exp.st || got.node !== exp.node || got.path_len !== exp.path_len ||
          got.pred !== exp.pred) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st=%0d node=%0d dist=%0d pred=%0d, ",
                    "got st=%0d node=%0d dist=%0d pred=%0d"},
                   exp.st, exp.node, exp.path_len, exp.pred,
                   got.st, got.node, got.path_len, got.pred);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  grid_dijkstra_shortest_path i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [EDGE_W-1:0] mask_mem [NODES];
  logic [15:0]       wgt_mem  [NODES][4];
  logic [DIST_W-1:0] dist_mem [NODES];
  logic [NODE_W-1:0] pred_mem [NODES];
  mark_e             mark_mem [NODES];
  bit                have_run;
  logic [CFG_W-1:0]  rows_q, cols_q;
  logic [NODE_W-1:0] src_q, tgt_q;

  path_scoreboard sb = new();
  int  items_sent;
  int  answers_seen = 0;
  int  cycles = 0;
  int  burst_left;

  initial begin
    for (int i = 0; i < NODES; i++) begin
      mask_mem[i] = '0;
      mark_mem[i] = MARK_UNSEEN;
    end
    have_run = 1'b0;
    rows_q = 1;
    cols_q = 1;
    src_q = 0;
    tgt_q = 0;
  end

  function automatic int grid_nodes();
    int n;
    n = int'(rows_q) * int'(cols_q);
    if (rows_q == 0 || cols_q == 0 || n > NODES) return 0;
    return n;
  endfunction

  function automatic void relax_edge(int from, int to, logic [15:0] w);
    logic [DIST_W:0] nd;
    nd = {1'b0, dist_mem[from]} + w;
    if (nd > DIST_MAX) nd = DIST_MAX;
    if (mark_mem[to] == MARK_UNSEEN) begin
      mark_mem[to] = MARK_FRONT;
      dist_mem[to] = nd[DIST_W-1:0];
      pred_mem[to] = NODE_W'(from);
    end else if (mark_mem[to] == MARK_FRONT && nd < dist_mem[to]) begin
      dist_mem[to] = nd[DIST_W-1:0];
      pred_mem[to] = NODE_W'(from);
    end
  endfunction

  function automatic void search_grid(int n);
    int  cur, r, c;
    bit  found;
    for (int i = 0; i < NODES; i++) mark_mem[i] = MARK_UNSEEN;
    mark_mem[src_q] = MARK_FRONT;
    dist_mem[src_q] = '0;
    pred_mem[src_q] = src_q;
    forever begin
      found = 1'b0;
      cur = 0;
      for (int i = 0; i < n; i++)
        if (mark_mem[i] == MARK_FRONT && (!found || dist_mem[i] < dist_mem[cur])) begin
          cur = i;
          found = 1'b1;
        end
      if (!found) break;
      mark_mem[cur] = MARK_DONE;
      r = cur / int'(cols_q);
      c = cur % int'(cols_q);
      if (mask_mem[cur][DIR_UP] && r != 0)
        relax_edge(cur, cur - int'(cols_q), wgt_mem[cur][DIR_UP]);
      if (mask_mem[cur][DIR_RIGHT] && c + 1 != int'(cols_q))
        relax_edge(cur, cur + 1, wgt_mem[cur][DIR_RIGHT]);
      if (mask_mem[cur][DIR_LEFT] && c != 0)
        relax_edge(cur, cur - 1, wgt_mem[cur][DIR_LEFT]);
      if (mask_mem[cur][DIR_DOWN] && r + 1 != int'(rows_q))
        relax_edge(cur, cur + int'(cols_q), wgt_mem[cur][DIR_DOWN]);
    end
  endfunction

  function automatic answer_t node_report(int node);
    answer_t a;
    a.node = NODE_W'(node);
    a.path_len = '0;
    a.pred = '0;
    if (mark_mem[node] == MARK_DONE) begin
      a.st = ST_OK;
      a.path_len = dist_mem[node];
      a.pred = pred_mem[node];
    end else begin
      a.st = ST_UNREACH;
    end
    return a;
  endfunction

  // apply one accepted item to the predictor and note its answer, if any
  function automatic void predict_item(cmd_e cmd, logic [IN_W-1:0] d);
    answer_t a;
    int n;
    int node;
    node = int'(d[9:0]);
    a.st = ST_OK;
    a.node = '0;
    a.path_len = '0;
    a.pred = '0;
    n = grid_nodes();
    case (cmd)
      CMD_LOAD: begin
        mask_mem[node] = d[13:10];
        for (int k = 0; k < 4; k++) wgt_mem[node][k] = d[14 + 16*k +: 16];
      end
      CMD_RUN: begin
        a.node = tgt_q;
        if (n == 0 || int'(src_q) >= n || int'(tgt_q) >= n) begin
          have_run = 1'b0;
          a.st = ST_RANGE;
        end else begin
          search_grid(n);
          have_run = 1'b1;
          a = node_report(int'(tgt_q));
        end
        sb.note_answer(a);
      end
      CMD_QUERY: begin
        a.node = NODE_W'(node);
        if (!have_run) a.st = ST_NORUN;
        else if (n == 0 || node >= n) a.st = ST_RANGE;
        else a = node_report(node);
        sb.note_answer(a);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(cmd_e cmd, int node, logic [3:0] mask,
                           logic [15:0] wu, logic [15:0] wr,
                           logic [15:0] wl, logic [15:0] wd);
    logic [IN_W-1:0] d;
    int gap;
    d = {2'b00, wd, wl, wr, wu, mask, NODE_W'(node)};
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_item(cmd, d);
    items_sent++;
    burst_left--;
  endtask

  function automatic logic [15:0] pick_weight(bit tiny);
    return tiny ? 16'($urandom_range(0, 3)) : 16'($urandom_range(0, 65535));
  endfunction

  task automatic load_node(int node, logic [3:0] mask, bit tiny);
    send_item(CMD_LOAD, node, mask, pick_weight(tiny), pick_weight(tiny),
              pick_weight(tiny), pick_weight(tiny));
  endtask

  task automatic send_simple(cmd_e cmd, int node);
    send_item(cmd, node, 4'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  // hold the sender until every answer is back and the block has gone quiet
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.waiting.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ROWS:   rows_q = CFG_W'(value);
      CFG_COLS:   cols_q = CFG_W'(value);
      CFG_SOURCE: src_q  = NODE_W'(value);
      default:    tgt_q  = NODE_W'(value);
    endcase
  endtask

  task automatic set_grid(int r, int c, int s, int t);
    drain_block();
    write_reg(CFG_ROWS, r);
    write_reg(CFG_COLS, c);
    write_reg(CFG_SOURCE, s);
    write_reg(CFG_TARGET, t);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_node(int n, output int node);
    if (n == 0 || $urandom_range(0, 9) == 0) node = $urandom_range(0, NODES - 1);
    else node = $urandom_range(0, n - 1);
  endtask

  // one grid: load every node if it holds at most 64, then runs, queries and noise
  task automatic grid_phase(int r, int c, int s, int t, bit tiny, int runs);
    int n;
    int node;
    logic [3:0] m;
    set_grid(r, c, s, t);
    n = grid_nodes();
    if (n > 0 && n <= 64)
      for (int i = 0; i < n; i++) begin
        m = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF;
        load_node(i, m, tiny);
      end
    for (int k = 0; k < runs; k++) begin
      send_simple(CMD_RUN, $urandom_range(0, NODES - 1));
      repeat ($urandom_range(4, 12)) begin
        pick_node(n, node);
        case ($urandom_range(0, 9))
          0: send_simple(CMD_NOP, node);
          1: load_node(node, 4'($urandom), tiny);
          default: send_simple(CMD_QUERY, node);
        endcase
      end
    end
  endtask

  // receiver: stall pattern that steps through four modes in turn, one long hold-off
  initial begin
    int  hold;
    bit  held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_answer(m_axis_tdata);
        answers_seen++;
      end
      if (!held && answers_seen == 60) begin
        held = 1'b1;
        hold = 800;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case ((cycles / 256) % 4)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int r, c, n;
    items_sent = 0;
    burst_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default single node grid, query before any run, capacity edge
    send_simple(CMD_QUERY, 0);
    send_simple(CMD_NOP, 5);
    send_item(CMD_LOAD, 0, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(CMD_LOAD, NODES - 1, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_simple(CMD_RUN, 0);
    send_simple(CMD_QUERY, 0);
    send_simple(CMD_QUERY, NODES - 1);
    // 2x2 with equal distances, so ties go to the lowest node
    set_grid(2, 2, 3, 0);
    send_item(CMD_LOAD, 0, 4'hF, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(CMD_LOAD, 1, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(CMD_LOAD, 2, 4'hF, 16'd5, 16'd5, 16'd5, 16'd5);
    send_item(CMD_LOAD, 3, 4'hF, 16'd5, 16'd5, 16'd5, 16'd5);
    send_simple(CMD_RUN, 0);
    for (int i = 0; i < 4; i++) send_simple(CMD_QUERY, i);
    // source out of grid clears the run
    set_grid(2, 2, 7, 0);
    send_simple(CMD_RUN, 0);
    send_simple(CMD_QUERY, 1);
    // bad grid sizes
    set_grid(1024, 1024, 0, 0);
    send_simple(CMD_RUN, 0);
    set_grid(0, 4, 0, 0);
    send_simple(CMD_RUN, 0);

    // largest grid, one run only since it is slow
    grid_phase(32, 32, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1), 1'b0, 1);
    grid_phase(1024, 1, 0, NODES - 1, 1'b0, 0);
    repeat (6) send_simple(CMD_QUERY, $urandom_range(0, NODES - 1));
    grid_phase(1, 8, 0, 7, 1'b1, 2);
    grid_phase(8, 1, 7, 0, 1'b0, 2);
    grid_phase(1, 1, 0, 0, 1'b0, 1);

    while (items_sent < N_ITEMS) begin
      r = $urandom_range(1, 8);
      c = $urandom_range(1, 8);
      n = r * c;
      if ($urandom_range(0, 7) == 0)
        grid_phase(r, c, $urandom_range(0, NODES - 1), $urandom_range(0, NODES - 1),
                   1'($urandom), 1);
      else
        grid_phase(r, c, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                   1'($urandom), $urandom_range(1, 3));
    end

    s_axis_tvalid <= 1'b0;
    while (sb.waiting.size() != 0) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.waiting.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/gdsp_pkg.sv
hdl/gdsp_lane.sv
hdl/gdsp_merge.sv
hdl/grid_dijkstra_shortest_path.sv
test/tb_top.sv
